// File: rtl/core/bmp_row_pixel_unpacker_core_macros.svh
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker_core_macros.svh
// Assertion macros shared by the bitmap row unpacker RTL.
// ----------------------------------------------------------------------------
`ifndef BMP_ROW_PIXEL_UNPACKER_CORE_MACROS_SVH
`define BMP_ROW_PIXEL_UNPACKER_CORE_MACROS_SVH

// generic concurrent assertion with explicit clock and active-low reset
`define BMP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// assertion on the block clock and reset
`define BMP_ASSERT_CLK(lbl, prop, msg) `BMP_ASSERT(lbl, aclk, aresetn, prop, msg)

`endif

// File: rtl/core/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Types, codes and helper functions of the bitmap row pixel unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

    // pixel format codes
    localparam logic [2:0] FMT_1  = 3'd0;
    localparam logic [2:0] FMT_4  = 3'd1;
    localparam logic [2:0] FMT_8  = 3'd2;
    localparam logic [2:0] FMT_16 = 3'd3;
    localparam logic [2:0] FMT_24 = 3'd4;
    localparam logic [2:0] FMT_32 = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd0;
    localparam logic [2:0] REG_BITFIELDS_MODE = 3'd1;
    localparam logic [2:0] REG_ROW_WIDTH      = 3'd2;
    localparam logic [2:0] REG_RED_MASK       = 3'd3;
    localparam logic [2:0] REG_GREEN_MASK     = 3'd4;
    localparam logic [2:0] REG_BLUE_MASK      = 3'd5;
    localparam logic [2:0] REG_ALPHA_MASK     = 3'd6;

    localparam int Q_DEPTH = 4;

    typedef enum logic [2:0] {
        JOB_PAL_WR,
        JOB_IDX1,
        JOB_IDX4,
        JOB_IDX8,
        JOB_W555,
        JOB_WRGB,
        JOB_WBF
    } job_kind_t;

    // one queued job: palette write, paletted byte, or assembled pixel word
    typedef struct packed {
        job_kind_t   kind;
        logic [3:0]  npix;
        logic        row_end;
        logic [31:0] data;
    } job_t;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic        bitfields_mode;
        logic [12:0] row_width;
    } stream_cfg_t;

    typedef struct packed {
        logic [4:0] lo;
        logic [7:0] fmask;
    } chan_sel_t;

    typedef struct packed {
        chan_sel_t red;
        chan_sel_t green;
        chan_sel_t blue;
        chan_sel_t alpha;
        logic      alpha_en;
    } field_cfg_t;

    // lowest set bit and 8-bit span mask of a channel mask
    function automatic chan_sel_t mask_sel(input logic [31:0] m);
        chan_sel_t  s;
        logic [5:0] lo;
        logic [5:0] hi;
        logic [5:0] span;
        lo = 6'd0;
        hi = 6'd0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) lo = 6'(i);
        end
        for (int i = 0; i < 32; i++) begin
            if (m[i]) hi = 6'(i + 1);
        end
        span = hi - lo;
        s.lo = lo[4:0];
        if (span >= 6'd8) s.fmask = 8'hff;
        else              s.fmask = (8'd1 << span[2:0]) - 8'd1;
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bmp_ram.sv
// ----------------------------------------------------------------------------
// bmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem_reg[waddr] <= wdata;
        if (re) rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/bmp_queue.sv
// ----------------------------------------------------------------------------
// bmp_queue
// Short job queue between the byte front end and the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bmp_row_pixel_unpacker_core_macros.svh"

module bmp_queue
    import bmp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    job_t          entry_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = wr_ptr_reg + PW'(1);
        if (pop)  rd_ptr_next = rd_ptr_reg + PW'(1);
        if (push && !pop)      count_next = count_reg + CW'(1);
        else if (pop && !push) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_job;
    end

    assign full       = (count_reg == CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    `BMP_ASSERT_CLK(a_q_no_overflow, push |-> (count_reg < CW'(Q_DEPTH)), "queue overflow")
    `BMP_ASSERT_CLK(a_q_no_underflow, pop |-> (count_reg != '0), "queue underflow")
    `BMP_ASSERT_CLK(a_q_count_up, (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)), "queue count slip")

endmodule

`default_nettype wire

// File: rtl/core/bmp_front.sv
// ----------------------------------------------------------------------------
// bmp_front
// Accepts row bytes and palette writes, tracks row position and pixel
// assembly, and queues one job per byte that yields work.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_front
    import bmp_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic        func,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  palette_index,
    input  wire logic [7:0]  palette_red,
    input  wire logic [7:0]  palette_green,
    input  wire logic [7:0]  palette_blue,
    input  stream_cfg_t      cfg,
    output logic             push,
    output job_t             push_job
);

    localparam int WW  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int BCW = WW + 3;

    logic [WW-1:0]  width;
    logic [WW+5:0]  row_bits;
    logic [WW+5:0]  row_bytes_raw;
    logic           paletted;
    logic [3:0]     per;
    logic [2:0]     need;
    job_kind_t      idx_kind;

    logic [BCW-1:0] row_bytes;
    logic [BCW-1:0] byte_cnt_reg, byte_cnt_next;
    logic [WW-1:0]  pix_cnt_reg, pix_cnt_next;
    logic [23:0]    asm_reg, asm_next;
    logic [1:0]     bip_reg, bip_next;

    logic [WW-1:0]  remain;
    logic [BCW:0]   byte_inc;
    logic [31:0]    word;

    always_comb begin
        if (cfg.row_width == 13'd0)
            width = WW'(1);
        else if (32'(cfg.row_width) > 32'(MAX_ROW_WIDTH))
            width = WW'(MAX_ROW_WIDTH);
        else
            width = WW'(cfg.row_width);
    end

    always_comb begin
        paletted = 1'b0;
        per      = 4'd1;
        need     = 3'd1;
        idx_kind = JOB_IDX8;
        row_bits = (WW+6)'(width) << 3;
        unique case (cfg.pixel_format)
            FMT_1: begin
                paletted = 1'b1;
                per      = 4'd8;
                idx_kind = JOB_IDX1;
                row_bits = (WW+6)'(width);
            end
            FMT_4: begin
                paletted = 1'b1;
                per      = 4'd2;
                idx_kind = JOB_IDX4;
                row_bits = (WW+6)'(width) << 2;
            end
            FMT_16: begin
                need     = 3'd2;
                row_bits = (WW+6)'(width) << 4;
            end
            FMT_24: begin
                need     = 3'd3;
                row_bits = ((WW+6)'(width) << 4) + ((WW+6)'(width) << 3);
            end
            FMT_32: begin
                need     = 3'd4;
                row_bits = (WW+6)'(width) << 5;
            end
            default: begin
                paletted = 1'b1;
                per      = 4'd1;
            end
        endcase
        row_bytes_raw = (((row_bits + (WW+6)'(7)) >> 3) + (WW+6)'(3)) >> 2;
    end

    assign row_bytes = BCW'(row_bytes_raw << 2);

    always_comb begin
        push          = 1'b0;
        push_job      = '0;
        byte_cnt_next = byte_cnt_reg;
        pix_cnt_next  = pix_cnt_reg;
        asm_next      = asm_reg;
        bip_next      = bip_reg;
        remain        = width - pix_cnt_reg;
        byte_inc      = (BCW+1)'(byte_cnt_reg) + (BCW+1)'(1);
        word          = ({8'd0, asm_reg} | (32'(data_byte) << {need - 3'd1, 3'd0}));
        if (need == 3'd2)      word = word & 32'h0000ffff;
        else if (need == 3'd3) word = word & 32'h00ffffff;

        if (accept) begin
            if (func) begin
                push          = 1'b1;
                push_job.kind = JOB_PAL_WR;
                push_job.npix = 4'd1;
                push_job.data = {palette_index, palette_red, palette_green, palette_blue};
            end else begin
                if (pix_cnt_reg < width) begin
                    if (paletted) begin
                        push             = 1'b1;
                        push_job.kind    = idx_kind;
                        push_job.data    = {24'd0, data_byte};
                        push_job.row_end = (remain <= WW'(per));
                        push_job.npix    = (remain < WW'(per)) ? remain[3:0] : per;
                        pix_cnt_next     = pix_cnt_reg + WW'(push_job.npix);
                    end else if (({1'b0, bip_reg} + 3'd1) < need) begin
                        asm_next = asm_reg | 24'(32'(data_byte) << {bip_reg, 3'd0});
                        bip_next = bip_reg + 2'd1;
                    end else begin
                        push             = 1'b1;
                        push_job.npix    = 4'd1;
                        push_job.data    = word;
                        push_job.row_end = (remain == WW'(1));
                        if (cfg.bitfields_mode && (need == 3'd2 || need == 3'd4))
                            push_job.kind = JOB_WBF;
                        else if (need == 3'd2)
                            push_job.kind = JOB_W555;
                        else
                            push_job.kind = JOB_WRGB;
                        asm_next     = '0;
                        bip_next     = '0;
                        pix_cnt_next = pix_cnt_reg + WW'(1);
                    end
                end
                byte_cnt_next = byte_inc[BCW-1:0];
                // close the row once the padded byte count is reached
                if (byte_inc >= (BCW+1)'(row_bytes)) begin
                    byte_cnt_next = '0;
                    pix_cnt_next  = '0;
                    asm_next      = '0;
                    bip_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg  <= '0;
            pix_cnt_reg   <= '0;
            asm_reg       <= '0;
            bip_reg       <= '0;
        end else begin
            byte_cnt_reg  <= byte_cnt_next;
            pix_cnt_reg   <= pix_cnt_next;
            asm_reg       <= asm_next;
            bip_reg       <= bip_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bmp_back.sv
// ----------------------------------------------------------------------------
// bmp_back
// Executes queued jobs: palette writes, palette lookups one pixel a cycle
// unless stalled, and channel extraction of words, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bmp_row_pixel_unpacker_core_macros.svh"

module bmp_back
    import bmp_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       head_valid,
    input  job_t            head_job,
    output logic            pop,
    input  field_cfg_t      fcfg,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic [7:0]      alpha,
    output logic            alpha_valid,
    output logic            row_end,
    output logic            last
);

    localparam int PIW = $clog2(PALETTE_DEPTH);

    logic [2:0]  j_reg, j_next;
    logic        adv, go, is_idx, final_pix, emit;
    logic [7:0]  byte_w, idx;
    logic        ram_we, ram_re;
    logic [23:0] ram_rdata;
    logic [7:0]  w_r, w_g, w_b, w_a;
    logic        w_av;
    logic [31:0] w;

    logic        b_valid_reg, b_valid_next;
    logic        b_pal_reg, b_oob_reg, b_last_reg, b_row_end_reg, b_av_reg;
    logic [7:0]  b_r_reg, b_g_reg, b_b_reg, b_a_reg;

    assign byte_w    = head_job.data[7:0];
    assign w         = head_job.data;
    assign adv       = !b_valid_reg || m_ready;
    assign go        = head_valid && adv;
    assign is_idx    = (head_job.kind == JOB_IDX1) || (head_job.kind == JOB_IDX4) ||
                       (head_job.kind == JOB_IDX8);
    assign final_pix = (4'(j_reg) == head_job.npix - 4'd1);
    assign pop       = go && (!is_idx || final_pix);
    assign emit      = go && (head_job.kind != JOB_PAL_WR);

    always_comb begin
        idx  = byte_w;
        w_r  = w[23:16];
        w_g  = w[15:8];
        w_b  = w[7:0];
        w_a  = 8'd0;
        w_av = 1'b0;
        unique case (head_job.kind)
            JOB_IDX1: idx = {7'd0, byte_w[3'd7 - j_reg]};
            JOB_IDX4: idx = (j_reg == 3'd0) ? {4'd0, byte_w[7:4]} : {4'd0, byte_w[3:0]};
            JOB_W555: begin
                w_r = {3'd0, w[14:10]};
                w_g = {3'd0, w[9:5]};
                w_b = {3'd0, w[4:0]};
            end
            JOB_WBF: begin
                w_r  = 8'(w >> fcfg.red.lo) & fcfg.red.fmask;
                w_g  = 8'(w >> fcfg.green.lo) & fcfg.green.fmask;
                w_b  = 8'(w >> fcfg.blue.lo) & fcfg.blue.fmask;
                w_av = fcfg.alpha_en;
                w_a  = fcfg.alpha_en ? (8'(w >> fcfg.alpha.lo) & fcfg.alpha.fmask) : 8'd0;
            end
            default: begin
            end
        endcase
    end

    assign ram_we = go && (head_job.kind == JOB_PAL_WR) &&
                    (9'(head_job.data[31:24]) < 9'(PALETTE_DEPTH));
    assign ram_re = go && is_idx;

    bmp_ram #(
        .WIDTH(24),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(head_job.data[PIW+23:24]),
        .wdata(head_job.data[23:0]),
        .re   (ram_re),
        .raddr(idx[PIW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb begin
        j_next = j_reg;
        if (go && is_idx) j_next = final_pix ? 3'd0 : j_reg + 3'd1;
        b_valid_next = b_valid_reg;
        if (adv) b_valid_next = emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg       <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            j_reg       <= j_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload of the output stage; palette data arrives from the RAM register
    always_ff @(posedge aclk) begin
        if (emit) begin
            b_pal_reg     <= is_idx;
            b_oob_reg     <= (9'(idx) >= 9'(PALETTE_DEPTH));
            b_last_reg    <= pop;
            b_row_end_reg <= pop && head_job.row_end;
            b_r_reg       <= w_r;
            b_g_reg       <= w_g;
            b_b_reg       <= w_b;
            b_a_reg       <= is_idx ? 8'd0 : w_a;
            b_av_reg      <= !is_idx && w_av;
        end
    end

    assign m_valid     = b_valid_reg;
    assign red         = b_pal_reg ? (b_oob_reg ? 8'd0 : ram_rdata[23:16]) : b_r_reg;
    assign green       = b_pal_reg ? (b_oob_reg ? 8'd0 : ram_rdata[15:8])  : b_g_reg;
    assign blue        = b_pal_reg ? (b_oob_reg ? 8'd0 : ram_rdata[7:0])   : b_b_reg;
    assign alpha       = b_a_reg;
    assign alpha_valid = b_av_reg;
    assign row_end     = b_row_end_reg;
    assign last        = b_last_reg;

    `BMP_ASSERT_CLK(a_b_hold, (b_valid_reg && !m_ready) |=> b_valid_reg, "output stage dropped")
    `BMP_ASSERT_CLK(a_b_j_range, (head_valid && is_idx) |-> (4'(j_reg) < head_job.npix), "pixel count overrun")
    `BMP_ASSERT_CLK(a_b_pop_emit, (pop && head_job.kind != JOB_PAL_WR) |-> emit, "job popped without pixel")

endmodule

`default_nettype wire

// File: rtl/core/bmp_row_pixel_unpacker_core.sv
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker_core
// Unpacks bitmap row bytes into one colour pixel per output transaction.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tdata: bytes+palette entry, tuser: func
//   m_       out  m_tvalid/m_tready  tdata: pixel+last, tuser: alpha_valid,
//                                    tlast: row_end
//   cfg_     in   cfg_valid/ready    cfg_index, cfg_data (always ready)
//
// One pixel leaves per cycle from the back end unless m_tready stalls it;
// 1-bit bytes yield up to eight pixels, 4-bit up to two, an 8-bit byte or
// a completed word one, palette writes none; other bytes queue no job.
// The palette RAM read port sets that rate. The first pixel of an input
// transaction passes the job queue and output stage registers to m_tvalid.
// Reset is synchronous and needs no clearing pass; the front keeps accepting
// while the job queue has room, independent of m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_row_pixel_unpacker_core
    import bmp_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // data_byte[7:0], palette_index[15:8], palette_red[23:16],
    // palette_green[31:24], palette_blue[39:32]
    input  wire logic [39:0] s_tdata,
    // func[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], last[32], zero[39:33]
    output logic [39:0]      m_tdata,
    // alpha_valid[0]
    output logic [0:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    stream_cfg_t cfg_reg;
    logic [31:0] red_mask_reg, green_mask_reg, blue_mask_reg, alpha_mask_reg;
    field_cfg_t  fcfg_reg;

    logic accept, push, full, head_valid, pop;
    job_t push_job, head_job;
    logic [7:0] red, green, blue, alpha;
    logic alpha_valid, row_end, last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format   <= FMT_8;
            cfg_reg.bitfields_mode <= 1'b0;
            cfg_reg.row_width      <= 13'd1;
            red_mask_reg           <= '0;
            green_mask_reg         <= '0;
            blue_mask_reg          <= '0;
            alpha_mask_reg         <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT:   cfg_reg.pixel_format   <= cfg_data[2:0];
                REG_BITFIELDS_MODE: cfg_reg.bitfields_mode <= cfg_data[0];
                REG_ROW_WIDTH:      cfg_reg.row_width      <= cfg_data[12:0];
                REG_RED_MASK:       red_mask_reg           <= cfg_data;
                REG_GREEN_MASK:     green_mask_reg         <= cfg_data;
                REG_BLUE_MASK:      blue_mask_reg          <= cfg_data;
                REG_ALPHA_MASK:     alpha_mask_reg         <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // mask decode is registered after the mask registers, settling within idle time
    always_ff @(posedge aclk) begin
        fcfg_reg.red      <= mask_sel(red_mask_reg);
        fcfg_reg.green    <= mask_sel(green_mask_reg);
        fcfg_reg.blue     <= mask_sel(blue_mask_reg);
        fcfg_reg.alpha    <= mask_sel(alpha_mask_reg);
        fcfg_reg.alpha_en <= (alpha_mask_reg != '0);
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    bmp_front #(
        .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .func         (s_tuser[0]),
        .data_byte    (s_tdata[7:0]),
        .palette_index(s_tdata[15:8]),
        .palette_red  (s_tdata[23:16]),
        .palette_green(s_tdata[31:24]),
        .palette_blue (s_tdata[39:32]),
        .cfg          (cfg_reg),
        .push         (push),
        .push_job     (push_job)
    );

    bmp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_job  (head_job)
    );

    bmp_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .fcfg       (fcfg_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .alpha_valid(alpha_valid),
        .row_end    (row_end),
        .last       (last)
    );

    assign m_tdata = {7'd0, last, alpha, blue, green, red};
    assign m_tuser = alpha_valid;
    assign m_tlast = row_end;

endmodule

`default_nettype wire

// File: sim/bmp_pixel_checker.sv
// ----------------------------------------------------------------------------
// bmp_pixel_checker
// Watches the row byte, pixel and register channels of the bitmap row
// unpacker, decodes every accepted byte into the pixels it should yield and
// compares them field by field with the pixels leaving the block.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_checker
    import bmp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic [0:0]  m_tuser,
    input  wire logic        m_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               pixels_pending,
    output int               fail_count
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       alpha_valid;
        logic       row_end;
        logic       last;
    } pixel_t;

    pixel_t      expected_pixels[$];
    logic [23:0] palette[256];
    logic [2:0]  fmt;
    logic        bf_mode;
    logic [12:0] width_reg;
    logic [31:0] masks[4];
    int          byte_count;
    int          pixel_count;
    logic [23:0] assembly;
    int          assembled_bytes;

    assign pixels_pending = expected_pixels.size();

    function automatic logic [7:0] channel_of(logic [31:0] word, logic [31:0] m);
        int lo;
        int hi;
        logic [31:0] span_mask;
        lo = -1;
        hi = 0;
        if (m == 0) return 8'd0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                if (lo < 0) lo = i;
                hi = i + 1;
            end
        end
        span_mask = (hi - lo == 32) ? 32'hffffffff : ((32'd1 << (hi - lo)) - 32'd1);
        return 8'((word >> lo) & span_mask);
    endfunction

    task automatic decode_row_byte(logic [7:0] b);
        int bpp;
        int width;
        int row_bytes;
        int need;
        int first;
        logic [31:0] w;
        logic [7:0] idx;
        pixel_t p;
        case (fmt)
            FMT_1:   bpp = 1;
            FMT_4:   bpp = 4;
            FMT_16:  bpp = 16;
            FMT_24:  bpp = 24;
            FMT_32:  bpp = 32;
            default: bpp = 8;
        endcase
        width = (width_reg == 0) ? 1 : (width_reg > 4096 ? 4096 : int'(width_reg));
        row_bytes = ((width * bpp + 7) / 8 + 3) & ~3;
        first = expected_pixels.size();
        if (pixel_count < width) begin
            if (bpp <= 8) begin
                for (int j = 0; j < 8 / bpp && pixel_count < width; j++) begin
                    idx = 8'((b >> (8 - bpp - j * bpp)) & ((1 << bpp) - 1));
                    pixel_count++;
                    p = '0;
                    {p.red, p.green, p.blue} = palette[idx];
                    p.row_end = (pixel_count == width);
                    expected_pixels.push_back(p);
                end
            end else begin
                need = bpp / 8;
                if (assembled_bytes + 1 < need) begin
                    assembly = 24'(assembly | (24'(b) << (8 * assembled_bytes)));
                    assembled_bytes++;
                end else begin
                    w = {8'd0, assembly} | (32'(b) << (8 * (need - 1)));
                    p = '0;
                    if (bf_mode && (need == 2 || need == 4)) begin
                        p.red   = channel_of(w, masks[0]);
                        p.green = channel_of(w, masks[1]);
                        p.blue  = channel_of(w, masks[2]);
                        if (masks[3] != 0) begin
                            p.alpha = channel_of(w, masks[3]);
                            p.alpha_valid = 1'b1;
                        end
                    end else if (need == 2) begin
                        p.red   = 8'(w[14:10]);
                        p.green = 8'(w[9:5]);
                        p.blue  = 8'(w[4:0]);
                    end else begin
                        p.red   = w[23:16];
                        p.green = w[15:8];
                        p.blue  = w[7:0];
                    end
                    assembly = '0;
                    assembled_bytes = 0;
                    pixel_count++;
                    p.row_end = (pixel_count == width);
                    expected_pixels.push_back(p);
                end
            end
        end
        byte_count++;
        if (byte_count >= row_bytes) begin
            byte_count = 0;
            pixel_count = 0;
            assembly = '0;
            assembled_bytes = 0;
        end
        if (expected_pixels.size() > first)
            expected_pixels[expected_pixels.size() - 1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (!aresetn) begin
            expected_pixels.delete();
            fmt = FMT_8;
            bf_mode = 1'b0;
            width_reg = 13'd1;
            for (int i = 0; i < 4; i++) masks[i] = '0;
            byte_count = 0;
            pixel_count = 0;
            assembly = '0;
            assembled_bytes = 0;
            fail_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                       m_tuser[0], m_tlast, m_tdata[32]};
                if (expected_pixels.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected pixel %h", got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want || m_tdata[39:33] !== 7'd0) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("pixel mismatch: expected %h got %h (tdata %h)",
                                     want, got, m_tdata);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PIXEL_FORMAT:   fmt = cfg_data[2:0];
                    REG_BITFIELDS_MODE: bf_mode = cfg_data[0];
                    REG_ROW_WIDTH:      width_reg = cfg_data[12:0];
                    REG_RED_MASK:       masks[0] = cfg_data;
                    REG_GREEN_MASK:     masks[1] = cfg_data;
                    REG_BLUE_MASK:      masks[2] = cfg_data;
                    REG_ALPHA_MASK:     masks[3] = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                // entry holds red, green, blue from the high byte down
                if (s_tuser[0])
                    palette[s_tdata[15:8]] = {s_tdata[23:16], s_tdata[31:24],
                                              s_tdata[39:32]};
                else decode_row_byte(s_tdata[7:0]);
            end
        end
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives palette loads and bitmap rows in every pixel depth, plain and
// bitfield, through the row unpacker with random gaps and back-pressure, and
// reports the verdict from the pixel checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import bmp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          pixels_pending;
    int          fail_count;
    int          cycle_count = 0;
    logic        hold_off;

    localparam int CYCLE_LIMIT = 400000;

    bmp_row_pixel_unpacker_core u_top (.*);

    bmp_pixel_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_length();
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        if ($urandom_range(2) == 0) return 0;
        return $urandom_range(3);
    endfunction

    // receiver stall: random, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else if ($urandom_range(15) == 0) m_tready <= 1'b0;
        else if (cycle_count % 600 < 150) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(9) != 0);
    end

    task automatic idle(int n);
        repeat (n) @(posedge aclk);
    endtask

    // keep tvalid high into the next transaction when there is no gap
    task automatic send(logic func, logic [39:0] payload);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= payload;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            idle(gap);
        end
    endtask

    task automatic send_row_byte(logic [7:0] b);
        send(1'b0, {$urandom(), b});
    endtask

    task automatic load_palette_entry(logic [7:0] idx, logic [23:0] rgb);
        send(1'b1, {rgb, idx, 8'($urandom())});
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // let the block drain before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pixels_pending != 0) @(posedge aclk);
        idle(12);
    endtask

    task automatic set_stream(logic [2:0] f, logic bf, logic [12:0] w);
        drain();
        write_reg(REG_PIXEL_FORMAT, 32'(f));
        write_reg(REG_BITFIELDS_MODE, 32'(bf));
        write_reg(REG_ROW_WIDTH, 32'(w));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_masks(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                             logic [31:0] a);
        drain();
        write_reg(REG_RED_MASK, r);
        write_reg(REG_GREEN_MASK, g);
        write_reg(REG_BLUE_MASK, b);
        write_reg(REG_ALPHA_MASK, a);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_rows(int nbytes);
        for (int i = 0; i < nbytes; i++) send_row_byte(8'($urandom()));
    endtask

    initial begin
        int fmt_pick;
        hold_off  = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PIXEL_FORMAT;
        cfg_data  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole palette so every index reads a written entry
        load_palette_entry(8'd0, 24'h000000);
        load_palette_entry(8'd255, 24'hffffff);
        for (int i = 1; i < 255; i++) load_palette_entry(8'(i), 24'($urandom()));
        load_palette_entry(8'd1, 24'hffffff);

        // directed: default 8-bit, width 1, extremes
        send_row_byte(8'h00);
        send_row_byte(8'hff);
        send_row_byte(8'h5a);
        send_row_byte(8'ha5);
        set_stream(FMT_1, 1'b0, 13'd9);
        send_row_byte(8'haa);
        send_row_byte(8'h55);
        send_row_byte(8'hff);
        send_row_byte(8'h00);
        set_stream(FMT_4, 1'b0, 13'd3);
        send_rows(4);
        set_stream(FMT_16, 1'b0, 13'd1);
        send_row_byte(8'hff);
        send_row_byte(8'hff);
        send_rows(2);
        set_stream(FMT_24, 1'b1, 13'd0);
        send_rows(4);
        set_masks(32'hff000000, 32'h00000ff0, 32'h0000000f, 32'h80000001);
        set_stream(FMT_32, 1'b1, 13'd1);
        send_rows(4);
        set_stream(3'd7, 1'b0, 13'd1);
        send_rows(4);

        // long receiver hold-off while bytes keep coming
        set_stream(FMT_1, 1'b0, 13'd64);
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_rows(8);
        join

        // random phases
        for (int ph = 0; ph < 5; ph++) begin
            fmt_pick = $urandom_range(7);
            if (ph == 3) set_stream(FMT_8, 1'b0, 13'h1fff);
            else if (ph == 4) set_stream(FMT_16, 1'b1, 13'd4096);
            else set_stream(3'(fmt_pick), 1'($urandom_range(1)),
                            13'($urandom_range(1, 12)));
            if ($urandom_range(2) == 0)
                set_masks($urandom(), $urandom(), $urandom(),
                          $urandom_range(1) ? 32'd0 : $urandom());
            else if ($urandom_range(1))
                set_masks(32'h00007c00, 32'h000003e0, 32'h0000001f, 32'h00008000);
            else
                set_masks(32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000);
            for (int k = 0; k < 14; k++) begin
                if ($urandom_range(11) == 0)
                    load_palette_entry(8'($urandom()), 24'($urandom()));
                else send_row_byte(8'($urandom()));
            end
        end

        drain();
        idle(20);
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/bmp_pkg.sv
rtl/core/bmp_ram.sv
rtl/core/bmp_queue.sv
rtl/core/bmp_front.sv
rtl/core/bmp_back.sv
rtl/core/bmp_row_pixel_unpacker_core.sv
sim/bmp_pixel_checker.sv
sim/testbench.sv
